[sv/sltq_pkg.sv]
// Shared types, widths and constants for the launch torque search block.
`default_nettype none

package sltq_pkg;

    // Field widths.
    localparam int SPEED_W  = 12;
    localparam int TORQUE_W = 13;
    localparam int STEP_W   = 10;
    localparam int SLIP_W   = 16;
    localparam int WSUM_W   = SPEED_W + 1;

    // Configuration port widths.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_TORQUE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RAMP_STEP      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLIP_LIMIT     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESET_SPEED    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_TORQUE = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_REF_SPEED  = 3'd5;

    // Register reset values.
    localparam logic [TORQUE_W-1:0] MAX_TORQUE_RST     = 13'd6000;
    localparam logic [STEP_W-1:0]   RAMP_STEP_RST      = 10'd100;
    localparam logic [SLIP_W-1:0]   SLIP_LIMIT_RST     = 16'd240;
    localparam logic [SPEED_W-1:0]  RESET_SPEED_RST    = 12'd480;
    localparam logic [TORQUE_W-1:0] DEFAULT_TORQUE_RST = 13'd1000;
    localparam logic [SPEED_W-1:0]  MIN_REF_SPEED_RST  = 12'd80;

    // Slip arithmetic: 0.5 km/h standstill threshold, 800 scales the
    // doubled wheel sum difference to 1/16 percent.
    localparam logic [SPEED_W-1:0] STANDSTILL_SPEED = 12'd8;
    localparam int SLIP_SCALE = 800;
    localparam int SCALE_W    = 10;
    localparam int NUMER_W    = WSUM_W + SCALE_W;

    // Launch torque is 19/20 of (ramp - step); the divide by 20 is a
    // multiply by a rounded-up reciprocal, exact for products below 2^18.
    localparam int LAUNCH_NUM   = 19;
    localparam int PROD19_W     = TORQUE_W + 5;
    localparam int RECIP_20     = 52429;
    localparam int RECIP_W      = 16;
    localparam int RECIP_SHIFT  = 20;
    localparam int RECIP_PROD_W = PROD19_W + RECIP_W;

    // Divider iteration counter.
    localparam int DIV_CNT_W = $clog2(NUMER_W + 1);

    // One input word.
    typedef struct packed {
        logic [SPEED_W-1:0] rear_left_speed;
        logic [SPEED_W-1:0] rear_right_speed;
        logic [SPEED_W-1:0] vehicle_speed;
        logic               brake_pressed;
    } in_word_t;

    // One result word.
    typedef struct packed {
        logic [TORQUE_W-1:0] torque_command;
        logic [SLIP_W-1:0]   slip_percent;
        logic                limit_found;
    } out_word_t;

    // Divider control and status.
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

[sv/slip_launch_torque_search.sv]
// Top level of the launch control torque search with its control sequencer.
`default_nettype none

// Each input word carries two rear wheel speeds, the vehicle speed and the
// brake state; each one gives exactly one result word with the torque
// command, the rear slip in 1/16 percent and the limit flag. The block takes
// one word at a time and is not ready while it works. A word with wheel slip
// passes through the serial divider for the slip ratio before its decision;
// a word that latches from a ramp above the ramp step then takes a multiply
// by 19 and a divide by 20 through the reciprocal. A word without slip skips
// the divider. The result waits in its output register until it is taken,
// and the next word is accepted in the cycle after that. Configuration writes
// take effect at once and belong to the idle time between words.
module slip_launch_torque_search
    import sltq_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire in_word_t               in_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output out_word_t                   out_data,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_DECIDE,
        S_MUL19,
        S_RECIP,
        S_OUT
    } state_t;

    // Configuration registers.
    logic [TORQUE_W-1:0] max_torque_reg;
    logic [STEP_W-1:0]   ramp_step_reg;
    logic [SLIP_W-1:0]   slip_limit_reg;
    logic [SPEED_W-1:0]  reset_speed_reg;
    logic [TORQUE_W-1:0] default_torque_reg;
    logic [SPEED_W-1:0]  min_ref_speed_reg;

    // Sequencer, sample and search state.
    state_t              state_reg;
    in_word_t            sample_reg;
    logic [NUMER_W-1:0]  numer_reg;
    logic [SPEED_W-1:0]  ref_reg;
    logic [SLIP_W-1:0]   slip_reg;
    logic [TORQUE_W-1:0] ramp_reg;
    logic [TORQUE_W-1:0] launch_reg;
    logic                done_reg;
    logic [TORQUE_W-1:0] excess_reg;
    logic [PROD19_W-1:0] prod19_reg;
    logic                div_start_reg;
    out_word_t           out_data_reg;

    // Divider connection.
    div_ctrl_t           div_ctrl;
    div_stat_t           div_stat;
    logic [NUMER_W-1:0]  div_quotient;

    // Combinational helpers.
    logic [SPEED_W-1:0]      ref_floor;
    logic                    standstill;
    logic [SPEED_W-1:0]      base_speed;
    logic [SPEED_W-1:0]      ref_speed;
    logic [WSUM_W-1:0]       wheel_sum;
    logic [WSUM_W-1:0]       base_twice;
    logic                    slipping;
    logic [WSUM_W-1:0]       slip_diff;
    logic [SLIP_W-1:0]       slip_sat;
    logic [TORQUE_W:0]       ramp_sum;
    logic [TORQUE_W-1:0]     ramp_next;
    logic [RECIP_PROD_W-1:0] recip_prod;
    logic [TORQUE_W-1:0]     cmd_release;

    // Slip reference: a zero floor counts as one, standstill uses the floor.
    assign ref_floor  = (min_ref_speed_reg == '0) ? SPEED_W'(1) : min_ref_speed_reg;
    assign standstill = sample_reg.vehicle_speed <= STANDSTILL_SPEED;
    assign base_speed = standstill ? ref_floor : sample_reg.vehicle_speed;
    assign ref_speed  = (standstill || (sample_reg.vehicle_speed < ref_floor))
                        ? ref_floor : sample_reg.vehicle_speed;
    assign wheel_sum  = WSUM_W'(sample_reg.rear_left_speed)
                      + WSUM_W'(sample_reg.rear_right_speed);
    assign base_twice = {base_speed, 1'b0};
    assign slipping   = wheel_sum > base_twice;
    assign slip_diff  = wheel_sum - base_twice;

    // Quotient saturates at the slip field maximum.
    assign slip_sat = (|div_quotient[NUMER_W-1:SLIP_W]) ? '1 : div_quotient[SLIP_W-1:0];

    // Ramp increment, saturating at the ceiling.
    assign ramp_sum  = {1'b0, ramp_reg} + (TORQUE_W + 1)'(ramp_step_reg);
    assign ramp_next = (ramp_sum > {1'b0, max_torque_reg})
                       ? max_torque_reg : ramp_sum[TORQUE_W-1:0];

    // Divide by 20 through the reciprocal.
    assign recip_prod = RECIP_PROD_W'(prod19_reg) * RECIP_PROD_W'(RECIP_20);

    assign cmd_release = done_reg ? launch_reg : default_torque_reg;

    assign div_ctrl.start = div_start_reg;

    sltq_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (numer_reg),
        .divisor  (ref_reg),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_torque_reg     <= MAX_TORQUE_RST;
            ramp_step_reg      <= RAMP_STEP_RST;
            slip_limit_reg     <= SLIP_LIMIT_RST;
            reset_speed_reg    <= RESET_SPEED_RST;
            default_torque_reg <= DEFAULT_TORQUE_RST;
            min_ref_speed_reg  <= MIN_REF_SPEED_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_TORQUE:     max_torque_reg     <= cfg_wdata[TORQUE_W-1:0];
                CFG_RAMP_STEP:      ramp_step_reg      <= cfg_wdata[STEP_W-1:0];
                CFG_SLIP_LIMIT:     slip_limit_reg     <= cfg_wdata[SLIP_W-1:0];
                CFG_RESET_SPEED:    reset_speed_reg    <= cfg_wdata[SPEED_W-1:0];
                CFG_DEFAULT_TORQUE: default_torque_reg <= cfg_wdata[TORQUE_W-1:0];
                CFG_MIN_REF_SPEED:  min_ref_speed_reg  <= cfg_wdata[SPEED_W-1:0];
                default:            ;
            endcase
        end
    end

    // Sequencer: capture, slip ratio, search decision, launch latch, output.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ramp_reg      <= '0;
            launch_reg    <= '0;
            done_reg      <= 1'b0;
            div_start_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        sample_reg <= in_data;
                        state_reg  <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    numer_reg <= NUMER_W'(slip_diff) * NUMER_W'(SLIP_SCALE);
                    ref_reg   <= ref_speed;
                    if (slipping)
                    begin
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DIV;
                    end
                    else
                    begin
                        slip_reg  <= '0;
                        state_reg <= S_DECIDE;
                    end
                end
                S_DIV:
                begin
                    if (div_stat.done)
                    begin
                        slip_reg  <= slip_sat;
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    out_data_reg.slip_percent <= slip_reg;
                    state_reg <= S_OUT;
                    if (sample_reg.brake_pressed)
                    begin
                        out_data_reg.torque_command <= ramp_reg;
                        out_data_reg.limit_found    <= 1'b1;
                        if (!done_reg)
                        begin
                            if ((slip_reg < slip_limit_reg) && (ramp_reg < max_torque_reg))
                            begin
                                ramp_reg <= ramp_next;
                                out_data_reg.torque_command <= ramp_next;
                                out_data_reg.limit_found    <= 1'b0;
                            end
                            else
                            begin
                                done_reg <= 1'b1;
                                if (ramp_reg > TORQUE_W'(ramp_step_reg))
                                begin
                                    excess_reg <= ramp_reg - TORQUE_W'(ramp_step_reg);
                                    state_reg  <= S_MUL19;
                                end
                                else
                                begin
                                    launch_reg <= '0;
                                end
                            end
                        end
                    end
                    else
                    begin
                        // Command is taken before the search may clear.
                        out_data_reg.torque_command <= cmd_release;
                        if (sample_reg.vehicle_speed > reset_speed_reg)
                        begin
                            done_reg <= 1'b0;
                            ramp_reg <= '0;
                            out_data_reg.limit_found <= 1'b0;
                        end
                        else
                        begin
                            out_data_reg.limit_found <= done_reg;
                        end
                    end
                end
                S_MUL19:
                begin
                    prod19_reg <= PROD19_W'(excess_reg) * PROD19_W'(LAUNCH_NUM);
                    state_reg  <= S_RECIP;
                end
                S_RECIP:
                begin
                    launch_reg <= recip_prod[RECIP_SHIFT+TORQUE_W-1:RECIP_SHIFT];
                    state_reg  <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    // The block never takes a word while a result is still pending.
    a_ready_excludes_result: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a result is pending");

    // Acceptance of a word drops ready in the next cycle.
    a_accept_drops_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready stayed high after an accepted word");

    // The divider is started only when it is free.
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctrl.start |-> !div_stat.busy)
        else $error("divider started while busy");

    // A started division finishes before the sequencer leaves its wait state.
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_DIV))
        else $error("divider finished outside the wait state");
`endif

endmodule

`default_nettype wire

[sv/sltq_divider.sv]
// Restoring serial divider for the slip ratio, one quotient bit per cycle.
`default_nettype none

module sltq_divider
    import sltq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire div_ctrl_t          ctrl,
    input  wire logic [NUMER_W-1:0] dividend,
    input  wire logic [SPEED_W-1:0] divisor,
    output div_stat_t               stat,
    output logic [NUMER_W-1:0]      quotient
);

    typedef enum logic {
        D_IDLE,
        D_RUN
    } dstate_t;

    dstate_t                state_reg;
    logic [DIV_CNT_W-1:0]   count_reg;
    logic [SPEED_W-1:0]     rem_reg;
    logic [NUMER_W-1:0]     quo_reg;
    logic [SPEED_W-1:0]     divisor_reg;
    logic                   done_reg;

    logic [SPEED_W:0]       trial;
    logic                   fits;

    // Shift the next dividend bit into the partial remainder and compare.
    assign trial = {rem_reg, quo_reg[NUMER_W-1]};
    assign fits  = trial >= {1'b0, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE:
                begin
                    if (ctrl.start)
                    begin
                        state_reg   <= D_RUN;
                        count_reg   <= DIV_CNT_W'(NUMER_W - 1);
                        rem_reg     <= '0;
                        quo_reg     <= dividend;
                        divisor_reg <= divisor;
                    end
                end
                D_RUN:
                begin
                    if (fits)
                    begin
                        rem_reg <= SPEED_W'(trial - {1'b0, divisor_reg});
                    end
                    else
                    begin
                        rem_reg <= trial[SPEED_W-1:0];
                    end
                    quo_reg <= {quo_reg[NUMER_W-2:0], fits};
                    if (count_reg == '0)
                    begin
                        state_reg <= D_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        count_reg <= count_reg - 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign stat.busy = (state_reg == D_RUN);
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire

[sim/testbench.sv]
// Testbench for the launch torque search block: directed and random words checked against a predictor.
`timescale 1ns / 100ps

module testbench;
    import sltq_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    in_word_t               in_data;
    logic                   out_valid;
    logic                   out_ready;
    out_word_t              out_data;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    // Register copies held by the predictor.
    int unsigned torque_ceiling;
    int unsigned ramp_increment;
    int unsigned slip_threshold;
    int unsigned clear_speed;
    int unsigned fallback_torque;
    int unsigned ref_speed_floor;

    // Search state held by the predictor.
    int unsigned ramp_level;
    int unsigned launch_level;
    bit          limit_latched;

    out_word_t   pending_results[$];
    int unsigned words_sent;
    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    slip_launch_torque_search dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The run is cut off if it hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** slip_launch_torque_search: FAILED **");
            $finish;
        end
    end

    // Result side backpressure.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Each accepted result word is compared with the oldest predicted one.
    always @(posedge clk)
    begin : check_results
        out_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result word: torque %0d slip %0d found %0d",
                             out_data.torque_command, out_data.slip_percent,
                             out_data.limit_found);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.torque_command !== want.torque_command ||
                    out_data.slip_percent !== want.slip_percent ||
                    out_data.limit_found !== want.limit_found)
                begin
                    error_count++;
                    if (error_count <= 10)
                    begin
                        $write("mismatch: torque exp %0d got %0d, slip exp %0d got %0d, ",
                               want.torque_command, out_data.torque_command,
                               want.slip_percent, out_data.slip_percent);
                        $display("found exp %0d got %0d",
                                 want.limit_found, out_data.limit_found);
                    end
                end
            end
        end
    end

    // Computes the result of one sample and advances the search state.
    function automatic out_word_t predict_launch(input in_word_t w);
        int unsigned wheel_sum;
        int unsigned floor_speed;
        int unsigned base_speed;
        int unsigned div_speed;
        int unsigned slip;
        int unsigned command;
        int unsigned raised;
        out_word_t   res;
        wheel_sum = w.rear_left_speed + w.rear_right_speed;
        floor_speed = (ref_speed_floor == 0) ? 1 : ref_speed_floor;

        // Standstill uses the floor speed as both baseline and divisor.
        if (w.vehicle_speed <= STANDSTILL_SPEED)
        begin
            base_speed = floor_speed;
            div_speed = floor_speed;
        end
        else
        begin
            base_speed = w.vehicle_speed;
            div_speed = (w.vehicle_speed < floor_speed) ? floor_speed : w.vehicle_speed;
        end
        if (wheel_sum > 2 * base_speed)
        begin
            slip = ((wheel_sum - 2 * base_speed) * SLIP_SCALE) / div_speed;
            if (slip > 65535)
                slip = 65535;
        end
        else
            slip = 0;

        if (w.brake_pressed)
        begin
            // Ramp while slip stays low, otherwise latch the launch torque.
            if (!limit_latched)
            begin
                if (slip < slip_threshold && ramp_level < torque_ceiling)
                begin
                    raised = ramp_level + ramp_increment;
                    ramp_level = (raised > torque_ceiling) ? torque_ceiling : raised;
                end
                else
                begin
                    limit_latched = 1'b1;
                    launch_level = (ramp_level > ramp_increment) ?
                                   ((ramp_level - ramp_increment) * 19) / 20 : 0;
                end
            end
            command = ramp_level;
        end
        else
        begin
            // The command is taken before a fast release clears the search.
            command = limit_latched ? launch_level : fallback_torque;
            if (w.vehicle_speed > clear_speed)
            begin
                limit_latched = 1'b0;
                ramp_level = 0;
            end
        end

        res.torque_command = command[TORQUE_W-1:0];
        res.slip_percent = slip[SLIP_W-1:0];
        res.limit_found = limit_latched;
        return res;
    endfunction

    function automatic in_word_t sample_word(input int unsigned left, input int unsigned right,
                                             input int unsigned speed, input bit brake);
        in_word_t w;
        w.rear_left_speed = left[SPEED_W-1:0];
        w.rear_right_speed = right[SPEED_W-1:0];
        w.vehicle_speed = speed[SPEED_W-1:0];
        w.brake_pressed = brake;
        return w;
    endfunction

    // A wheel speed a random amount above the given speed.
    function automatic int unsigned near_speed(input int unsigned speed,
                                               input int unsigned spread);
        int unsigned s;
        s = speed + $urandom_range(0, spread);
        return (s > 4095) ? 4095 : s;
    endfunction

    function automatic in_word_t noise_word();
        return sample_word($urandom_range(0, 4095), $urandom_range(0, 4095),
                           $urandom_range(0, 4095), $urandom_range(0, 1));
    endfunction

    // Offers one word, holds it until accepted, then records its prediction.
    task automatic send_word(input in_word_t w);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(predict_launch(w));
        words_sent++;
    endtask

    // Lets every outstanding result drain so that the block is idle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        case (idx)
            CFG_MAX_TORQUE:     torque_ceiling = val[TORQUE_W-1:0];
            CFG_RAMP_STEP:      ramp_increment = val[STEP_W-1:0];
            CFG_SLIP_LIMIT:     slip_threshold = val[SLIP_W-1:0];
            CFG_RESET_SPEED:    clear_speed = val[SPEED_W-1:0];
            CFG_DEFAULT_TORQUE: fallback_torque = val[TORQUE_W-1:0];
            CFG_MIN_REF_SPEED:  ref_speed_floor = val[SPEED_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_settings(input int unsigned ceiling, input int unsigned step,
                                    input int unsigned limit, input int unsigned clr,
                                    input int unsigned dflt, input int unsigned floor_spd);
        write_reg(CFG_MAX_TORQUE, ceiling);
        write_reg(CFG_RAMP_STEP, step);
        write_reg(CFG_SLIP_LIMIT, limit);
        write_reg(CFG_RESET_SPEED, clr);
        write_reg(CFG_DEFAULT_TORQUE, dflt);
        write_reg(CFG_MIN_REF_SPEED, floor_spd);
        cfg_we <= 1'b0;
    endtask

    // A braked ramp ending in a slip burst, a launch, and usually a clear.
    task automatic launch_sequence();
        int unsigned braked_n;
        int unsigned released_n;
        int unsigned k;
        int unsigned speed;
        int unsigned spread;
        braked_n = $urandom_range(1, 12);
        for (k = 0; k < braked_n; k++)
        begin
            speed = ($urandom_range(3) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 200);
            spread = (k == braked_n - 1) ? $urandom_range(0, 1500) : $urandom_range(0, 12);
            send_word(sample_word(near_speed(speed, spread), near_speed(speed, spread),
                                  speed, 1'b1));
        end
        released_n = $urandom_range(0, 4);
        for (k = 0; k < released_n; k++)
        begin
            speed = $urandom_range(0, clear_speed);
            send_word(sample_word(near_speed(speed, 30), near_speed(speed, 30), speed, 1'b0));
        end
        if ($urandom_range(3) != 0 && clear_speed < 4095)
        begin
            speed = $urandom_range(clear_speed + 1, 4095);
            send_word(sample_word(near_speed(speed, 30), near_speed(speed, 30), speed, 1'b0));
        end
    endtask

    // Mostly well formed launches, the rest random words.
    task automatic run_mix(input int unsigned count);
        int unsigned first;
        first = words_sent;
        while (words_sent - first < count)
        begin
            if ($urandom_range(99) < 80)
                launch_sequence();
            else
                send_word(noise_word());
        end
    endtask

    // Sweeps through samples under the reset register values.
    task automatic test_reset_defaults();
        send_word(sample_word(0, 0, 0, 1'b0));
        send_word(sample_word(0, 0, 0, 1'b1));
        // Saturating slip at standstill latches with nothing to back off.
        send_word(sample_word(4095, 4095, 0, 1'b1));
        // Braked after latching keeps the ramp.
        send_word(sample_word(90, 90, 8, 1'b1));
        send_word(sample_word(4095, 4095, 4095, 1'b0));
        send_word(sample_word(0, 0, 480, 1'b0));
        send_word(sample_word(4095, 0, 9, 1'b1));
        send_word(sample_word(0, 4095, 481, 1'b0));
    endtask

    // Ramp saturation at the ceiling and a ceiling lowered under the ramp.
    task automatic test_ramp_ceiling();
        wait_idle();
        program_settings(250, 100, 65535, 480, 1000, 80);
        repeat (3) send_word(sample_word(0, 0, 20, 1'b1));
        send_word(sample_word(0, 0, 20, 1'b1));
        send_word(sample_word(0, 0, 100, 1'b0));
        send_word(sample_word(0, 0, 4095, 1'b0));
        repeat (2) send_word(sample_word(10, 10, 20, 1'b1));
        wait_idle();
        program_settings(150, 100, 65535, 480, 1000, 80);
        send_word(sample_word(10, 10, 20, 1'b1));
        send_word(sample_word(0, 0, 100, 1'b0));
    endtask

    // A zero floor speed acts as one; the clear speed at both ends.
    task automatic test_zero_reference();
        wait_idle();
        program_settings(8000, 1000, 65535, 4095, 8000, 0);
        send_word(sample_word(1, 2, 0, 1'b1));
        send_word(sample_word(10, 10, 9, 1'b1));
        send_word(sample_word(4095, 4095, 4095, 1'b0));
        wait_idle();
        program_settings(8000, 1000, 65535, 0, 8000, 0);
        send_word(sample_word(0, 0, 1, 1'b0));
        send_word(sample_word(0, 0, 0, 1'b0));
    endtask

    // Random traffic under low and then high register values.
    task automatic test_register_extremes();
        wait_idle();
        program_settings(0, 1, 0, 0, 0, 1);
        run_mix(30);
        wait_idle();
        program_settings(8000, 1000, 65535, 4095, 8000, 4095);
        run_mix(30);
    endtask

    // Random settings and traffic under each idling pattern.
    task automatic test_random_launches();
        int unsigned mode;
        for (mode = 0; mode < 4; mode++)
        begin
            case (mode)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            repeat (2)
            begin
                wait_idle();
                if ($urandom_range(1) == 0)
                    program_settings($urandom_range(0, 8000), $urandom_range(1, 1000),
                                     $urandom_range(0, 2000), $urandom_range(0, 4095),
                                     $urandom_range(0, 8000), $urandom_range(1, 300));
                else
                    program_settings($urandom_range(0, 1500), $urandom_range(50, 1000),
                                     $urandom_range(0, 65535), $urandom_range(0, 600),
                                     $urandom_range(0, 8000), $urandom_range(1, 4095));
                run_mix(85);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        words_sent = 0;
        error_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;

        // Predictor state after reset.
        torque_ceiling = MAX_TORQUE_RST;
        ramp_increment = RAMP_STEP_RST;
        slip_threshold = SLIP_LIMIT_RST;
        clear_speed = RESET_SPEED_RST;
        fallback_torque = DEFAULT_TORQUE_RST;
        ref_speed_floor = MIN_REF_SPEED_RST;
        ramp_level = 0;
        launch_level = 0;
        limit_latched = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_ramp_ceiling();
        test_zero_reference();
        test_register_extremes();
        test_random_launches();

        // Drain, then watch a while for stray results.
        wait_idle();
        repeat (40) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("** slip_launch_torque_search: PASSED **");
        else
            $display("** slip_launch_torque_search: FAILED **");
        $finish;
    end

endmodule
